/* sv/assert_macros.svh */
// Assertion macros shared by the mismatch scanner modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RMCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after the trigger.
`define RMCS_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* sv/rmcs_pkg.sv */
// Shared types and constants for the read mismatch cluster scanner.
// Used by rmcs_span_mem, rmcs_emitter and the top level; no dependencies.
package rmcs_pkg;

	localparam int MAX_VARIANT_LEN = 64;
	localparam int BUF_DEPTH = MAX_VARIANT_LEN + 16;
	localparam int BUF_AW = $clog2(BUF_DEPTH);
	localparam int LEN_W = $clog2(MAX_VARIANT_LEN + 1);
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [7:0] UNKNOWN_BASE = 8'h4E;

	// configuration register indexes
	localparam logic [1:0] REG_GAP_MATCHES = 2'd0;
	localparam logic [1:0] REG_QUAL_OFFSET = 2'd1;
	localparam logic [1:0] REG_LOW_QUAL_LIMIT = 2'd2;

	localparam logic [3:0] GAP_MATCHES_RST = 4'd5;
	localparam logic [7:0] QUAL_OFFSET_RST = 8'd33;
	localparam logic [7:0] LOW_QUAL_LIMIT_RST = 8'd25;

	typedef enum logic [0:0] {
		EMIT_IDLE,
		EMIT_RUN
	} emit_state_t;

	// request to replay one closed variant
	typedef struct packed {
		logic              valid;
		logic [31:0]       pos;
		logic [LEN_W-1:0]  len;
		logic              low_quality;
		logic              too_long;
	} emit_req_t;

	typedef struct packed {
		logic [7:0] ref_base;
		logic [7:0] alt_base;
	} allele_pair_t;

endpackage

/* sv/rmcs_span_mem.sv */
// Allele buffer: one write port, one read port with registered read data.
// Depends on rmcs_pkg for depth and entry type.
module rmcs_span_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rmcs_pkg::BUF_AW-1:0] waddr,
	input  rmcs_pkg::allele_pair_t      wdata,
	input  logic                        re,
	input  logic [rmcs_pkg::BUF_AW-1:0] raddr,
	output rmcs_pkg::allele_pair_t      rdata
);

	rmcs_pkg::allele_pair_t mem [rmcs_pkg::BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/rmcs_emitter.sv */
// Replays a closed variant from the allele buffer onto the result channel.
// Depends on rmcs_pkg and assert_macros.svh; drives the buffer read port.
`include "assert_macros.svh"

module rmcs_emitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rmcs_pkg::emit_req_t         req,
	output logic                        busy,
	output logic                        rd_en,
	output logic [rmcs_pkg::BUF_AW-1:0] rd_addr,
	input  rmcs_pkg::allele_pair_t      rd_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [31:0]                 variant_pos,
	output logic [5:0]                  base_index,
	output logic [7:0]                  ref_allele_base,
	output logic [7:0]                  alt_allele_base,
	output logic                        low_quality,
	output logic                        too_long,
	output logic                        variant_last
);

	rmcs_pkg::emit_state_t state_q, state_d;

	logic [rmcs_pkg::LEN_W-1:0] idx_q;
	logic [rmcs_pkg::LEN_W-1:0] len_q;
	logic [31:0]                pos_q;
	logic                       low_q;
	logic                       long_q;

	logic                       rd_s1;
	logic [rmcs_pkg::LEN_W-1:0] idx_s1;
	logic                       last_s1;

	logic                       out_free;
	logic                       issue;
	logic                       issue_last;
	logic [rmcs_pkg::LEN_W-1:0] idx_next;

	// a read is issued only when the output register is empty by the next cycle
	assign out_free   = !out_valid || !out_stall;
	assign issue      = (state_q == rmcs_pkg::EMIT_RUN) && !rd_s1 && out_free;
	assign idx_next   = idx_q + 1'b1;
	assign issue_last = long_q || (idx_next == len_q);

	assign rd_en   = issue;
	assign rd_addr = rmcs_pkg::BUF_AW'(idx_q);
	assign busy    = (state_q == rmcs_pkg::EMIT_RUN) || rd_s1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rmcs_pkg::EMIT_IDLE: begin
				if (req.valid) begin
					state_d = rmcs_pkg::EMIT_RUN;
				end
			end
			rmcs_pkg::EMIT_RUN: begin
				if (issue && issue_last) begin
					state_d = rmcs_pkg::EMIT_IDLE;
				end
			end
			default: state_d = rmcs_pkg::EMIT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmcs_pkg::EMIT_IDLE;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && state_q == rmcs_pkg::EMIT_IDLE) begin
			idx_q  <= '0;
			len_q  <= req.len;
			pos_q  <= req.pos;
			low_q  <= req.low_quality;
			long_q <= req.too_long;
		end else if (issue) begin
			idx_q <= idx_next;
		end
		if (issue) begin
			idx_s1  <= idx_q;
			last_s1 <= issue_last;
		end
	end

	// output register: load when read data returns, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rd_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			variant_pos     <= pos_q;
			low_quality     <= low_q;
			too_long        <= long_q;
			variant_last    <= last_s1;
			base_index      <= long_q ? 6'd0 : idx_s1[5:0];
			ref_allele_base <= long_q ? 8'd0 : rd_data.ref_base;
			alt_allele_base <= long_q ? 8'd0 : rd_data.alt_base;
		end
	end

	`RMCS_ASSERT(a_out_free_on_return, rd_s1 |-> !out_valid, "read data returned to a full output register")
	`RMCS_ASSERT_NEXT(a_return_loads, rd_s1, out_valid, "returned read data was not loaded")
	`RMCS_ASSERT(a_no_req_while_busy, req.valid |-> !busy, "variant replay requested while busy")

endmodule

/* sv/read_mismatch_cluster_scanner_unit.sv */
// Read mismatch cluster scanner: groups read/reference mismatches into
// variants and replays each closed variant with no unknown base in its span as ref/alt base pairs.
// Input channel (in_valid/in_stall) takes one aligned base per transfer:
// reference, read and quality characters, coordinate and end-of-read mark.
// Output channel (out_valid/out_stall) gives one result per variant base, or a
// single too_long result for a span over MAX_VARIANT_LEN.
// A base that closes no variant does not stall the input. A base that closes a variant
// holds in_stall high while the span replays from the allele buffer: each buffer
// read returns its data to the output register before the next read is issued, and
// the first result follows the closing transfer through the emitter state, the buffer
// read data register and the output register.
// The last result may wait in the output register while new bases are taken.
// A stall on the output holds the current result and delays the replay.
// Reset clears the variant state and loads the registers with their defaults
// (gap_matches 5, qual_offset 33, low_qual_limit 25); the buffer is not
// cleared. Write configuration (cfg_we, cfg_addr, cfg_data) only while idle.
// Depends on rmcs_pkg, rmcs_span_mem, rmcs_emitter and assert_macros.svh.
`include "assert_macros.svh"

module read_mismatch_cluster_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ref_base,
	input  logic [7:0]  read_base,
	input  logic [7:0]  base_quality,
	input  logic [31:0] genome_pos,
	input  logic        end_of_read,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] variant_pos,
	output logic [5:0]  base_index,
	output logic [7:0]  ref_allele_base,
	output logic [7:0]  alt_allele_base,
	output logic        low_quality,
	output logic        too_long,
	output logic        variant_last
);

	localparam int CW = rmcs_pkg::CNT_W;

	logic [3:0] gap_q;
	logic [7:0] qoff_q;
	logic [7:0] qlim_q;

	logic          open_q;
	logic [CW-1:0] cnt_q;
	logic [3:0]    trail_q;
	logic [31:0]   start_q;
	logic [7:0]    rmin_q;
	logic [7:0]    smin_q;
	logic          runk_q;
	logic          sunk_q;

	logic          acc;
	logic          busy;
	logic          mismatch;
	logic          append;
	logic [3:0]    gap_eff;
	logic [CW-1:0] cnt_b, cnt_n, span;
	logic [7:0]    rmin_b, rmin_n, smin_n;
	logic          runk_b, runk_n, sunk_n;
	logic [4:0]    trail_n;
	logic [31:0]   start_n;
	logic          close;
	logic          low;
	logic          wr_en;

	rmcs_pkg::emit_req_t    req;
	rmcs_pkg::allele_pair_t wr_pair;
	rmcs_pkg::allele_pair_t rd_data;
	logic                   rd_en;
	logic [rmcs_pkg::BUF_AW-1:0] rd_addr;

	assign in_stall = busy;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= rmcs_pkg::GAP_MATCHES_RST;
			qoff_q <= rmcs_pkg::QUAL_OFFSET_RST;
			qlim_q <= rmcs_pkg::LOW_QUAL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				rmcs_pkg::REG_GAP_MATCHES:    gap_q  <= cfg_data[3:0];
				rmcs_pkg::REG_QUAL_OFFSET:    qoff_q <= cfg_data;
				rmcs_pkg::REG_LOW_QUAL_LIMIT: qlim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		gap_eff  = (gap_q == 4'd0) ? 4'd1 : gap_q;
		mismatch = (ref_base != read_base) && (read_base != rmcs_pkg::UNKNOWN_BASE);
		append   = mismatch || open_q;

		// a new variant starts from fresh running state
		cnt_b   = open_q ? cnt_q : '0;
		rmin_b  = open_q ? rmin_q : 8'hFF;
		runk_b  = open_q && runk_q;
		start_n = open_q ? start_q : genome_pos;

		cnt_n  = (cnt_b == rmcs_pkg::CNT_MAX) ? cnt_b : cnt_b + 1'b1;
		rmin_n = (base_quality < rmin_b) ? base_quality : rmin_b;
		runk_n = runk_b || (ref_base == rmcs_pkg::UNKNOWN_BASE)
			|| (read_base == rmcs_pkg::UNKNOWN_BASE);

		if (mismatch) begin
			trail_n = '0;
			smin_n  = rmin_n;
			sunk_n  = runk_n;
		end else begin
			trail_n = {1'b0, trail_q} + 5'd1;
			smin_n  = smin_q;
			sunk_n  = sunk_q;
		end

		close = append && ((trail_n >= {1'b0, gap_eff}) || end_of_read);
		span  = cnt_n - CW'(trail_n);
		low   = (smin_n >= qoff_q) && ((smin_n - qoff_q) < qlim_q);
		wr_en = acc && append && (cnt_b < CW'(rmcs_pkg::BUF_DEPTH));

		req.valid       = acc && close && !sunk_n;
		req.pos         = start_n;
		req.too_long    = span > CW'(rmcs_pkg::MAX_VARIANT_LEN);
		req.len         = rmcs_pkg::LEN_W'(span);
		req.low_quality = low;

		wr_pair.ref_base = ref_base;
		wr_pair.alt_base = read_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			cnt_q   <= '0;
			trail_q <= '0;
			start_q <= '0;
			rmin_q  <= 8'hFF;
			smin_q  <= 8'hFF;
			runk_q  <= 1'b0;
			sunk_q  <= 1'b0;
		end else if (acc && append) begin
			start_q <= start_n;
			if (close) begin
				open_q  <= 1'b0;
				cnt_q   <= '0;
				trail_q <= '0;
				rmin_q  <= 8'hFF;
				smin_q  <= 8'hFF;
				runk_q  <= 1'b0;
				sunk_q  <= 1'b0;
			end else begin
				open_q  <= 1'b1;
				cnt_q   <= cnt_n;
				trail_q <= trail_n[3:0];
				rmin_q  <= rmin_n;
				smin_q  <= smin_n;
				runk_q  <= runk_n;
				sunk_q  <= sunk_n;
			end
		end
	end

	rmcs_span_mem u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_b[rmcs_pkg::BUF_AW-1:0]),
		.wdata (wr_pair),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rmcs_emitter u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.busy            (busy),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.variant_pos     (variant_pos),
		.base_index      (base_index),
		.ref_allele_base (ref_allele_base),
		.alt_allele_base (alt_allele_base),
		.low_quality     (low_quality),
		.too_long        (too_long),
		.variant_last    (variant_last)
	);

	`RMCS_ASSERT(a_closed_state_clear, !open_q |-> (cnt_q == '0 && trail_q == '0), "closed variant left state behind")
	`RMCS_ASSERT(a_trail_in_span, open_q |-> (CW'(trail_q) < cnt_q), "trailing matches cover the whole span")
	`RMCS_ASSERT_NEXT(a_close_stalls, req.valid, in_stall, "input not stalled during replay")

endmodule
